@@ hdl/lkv_pkg.sv @@
// Package for the LRU key-value cache: sizes, codes, beat payload types
// and controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = IDX_W;
    localparam int CAP_W   = 5;
    localparam int EC_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic             KIND_LOOKUP  = 1'b0;
    localparam logic             KIND_STORE   = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE  = '1;
    localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
    localparam logic              REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] key;
        logic signed [31:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_out_item;

    typedef struct packed {
        logic             load;
        logic             scan;
        logic [IDX_W-1:0] addr;
        logic             fetch;
        logic             commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/lkv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lkv_ctrl.sv @@
// Sequencer for the LRU cache: accept, scan entries, drain, fetch, commit.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl
    import lkv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.addr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.fetch = 1'b1;
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lkv_dp.sv @@
// Datapath for the LRU cache: key/data RAMs, valid bits, recency ranks,
// occupancy, capacity register and result register. Depends on lkv_pkg, lkv_ram.
`timescale 1ns / 1ps
`default_nettype none

module lkv_dp
    import lkv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in_item          i_in_data,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [APB_AW-1:0] i_cfg_addr,
    input  wire logic [APB_DW-1:0] i_cfg_wdata,
    output logic      [APB_DW-1:0] o_cfg_rdata
);

    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_val;
    logic [CAP_W-1:0]   r_cap;
    logic               r_valid [ENTRIES];
    logic [RANK_W-1:0]  r_rank  [ENTRIES];
    logic               n_valid [ENTRIES];
    logic [RANK_W-1:0]  n_rank  [ENTRIES];
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic               r_ev_cond;
    logic               r_hit;
    logic [IDX_W-1:0]   r_found;
    logic               r_have_slot;
    logic [IDX_W-1:0]   r_slot;
    logic [IDX_W-1:0]   r_oldest;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [KEY_W-1:0]   w_key_rd;
    logic [DATA_W-1:0]  w_data_rd;
    logic [IDX_W-1:0]   w_key_raddr;
    logic [IDX_W-1:0]   w_data_waddr;
    logic [EC_W-1:0]    w_cap_ext;
    logic [EC_W-1:0]    w_eff_cap;
    logic [RANK_W-1:0]  w_last_rank;
    logic               w_cv;
    logic [RANK_W-1:0]  w_cr;
    logic               w_is_old;
    logic               w_miss_store;
    logic               w_do_ev;
    logic [RANK_W-1:0]  w_found_rank;

    assign w_key_raddr  = i_cmd.fetch ? r_oldest : i_cmd.addr;
    assign w_data_waddr = r_hit ? r_found : r_slot;

    lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_miss_store),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rd)
    );

    lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && (r_kind == KIND_STORE)),
        .i_waddr (w_data_waddr),
        .i_wdata (r_val),
        .i_raddr (r_found),
        .o_rdata (w_data_rd)
    );

    assign w_cap_ext = EC_W'(r_cap);
    assign w_eff_cap = (r_cap == '0) ? EC_W'(1) :
                       (w_cap_ext > EC_W'(ENTRIES)) ? EC_W'(ENTRIES) : w_cap_ext;
    assign w_last_rank = RANK_W'(r_occ - CNT_W'(1));

    assign w_cv     = r_valid[r_cmp_idx];
    assign w_cr     = r_rank[r_cmp_idx];
    assign w_is_old = w_cv && (w_cr == w_last_rank) && (r_occ != '0);

    assign w_miss_store = (r_kind == KIND_STORE) && !r_hit;
    assign w_do_ev      = w_miss_store && r_ev_cond;
    assign w_found_rank = r_rank[r_found];

    always_comb begin
        n_occ = r_occ;
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (r_hit) begin
                if (IDX_W'(i) == r_found) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < w_found_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (w_miss_store) begin
                if (IDX_W'(i) == r_slot) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (w_do_ev && (IDX_W'(i) == r_oldest)) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
        if (w_miss_store && !w_do_ev) begin
            n_occ = r_occ + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_data.kind;
            r_key  <= i_in_data.key;
            r_val  <= i_in_data.store_value;
        end
        if (i_cmd.commit) begin
            r_out.hit         <= r_hit;
            r_out.read_value  <= ((r_kind == KIND_LOOKUP) && r_hit) ? w_data_rd : MISS_VALUE;
            r_out.evicted     <= w_do_ev;
            r_out.evicted_key <= w_do_ev ? w_key_rd : '0;
        end
        r_cmp_idx <= i_cmd.addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_ev_cond   <= 1'b0;
            r_hit       <= 1'b0;
            r_found     <= '0;
            r_have_slot <= 1'b0;
            r_slot      <= '0;
            r_oldest    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cfg_we && (i_cfg_addr[2] == REG_CAPACITY)) begin
                r_cap <= i_cfg_wdata[CAP_W-1:0];
            end
            if (i_cmd.load) begin
                r_ev_cond   <= (i_in_data.kind == KIND_STORE) &&
                               (EC_W'(r_occ) >= w_eff_cap) && (r_occ != '0);
                r_hit       <= 1'b0;
                r_found     <= '0;
                r_have_slot <= 1'b0;
                r_slot      <= '0;
                r_oldest    <= '0;
            end
            if (r_cmp_vld) begin
                if (!r_hit && w_cv && (w_key_rd == r_key)) begin
                    r_hit   <= 1'b1;
                    r_found <= r_cmp_idx;
                end
                if (!r_have_slot && (!w_cv || (r_ev_cond && w_is_old))) begin
                    r_have_slot <= 1'b1;
                    r_slot      <= r_cmp_idx;
                end
                if (w_is_old) begin
                    r_oldest <= r_cmp_idx;
                end
            end
            if (i_cmd.commit) begin
                r_occ <= n_occ;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_valid[i] <= n_valid[i];
                    r_rank[i]  <= n_rank[i];
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_cfg_rdata       = (i_cfg_addr[2] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    logic [ENTRIES-1:0] w_valid_vec;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid_vec[i] = r_valid[i];
        end
    end

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) == $countones(w_valid_vec))
        else $error("occupancy differs from valid count");

    a_hit_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit) |-> r_valid[r_found])
        else $error("hit on an invalid entry");

    a_store_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_miss_store) |-> r_have_slot)
        else $error("store miss without a free slot");

    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result beat without commit");

endmodule

`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// LRU key-value cache top level: joins the sequencer and the datapath.
// Depends on lkv_pkg, lkv_ctrl, lkv_dp, lkv_ram.
// A new input beat is taken only in idle; the sequencer then scans every entry,
// drains, fetches and commits; o_out_valid rises after commit. The scan reads one
// entry per cycle via the key RAM read port; a stalled result beat holds the commit.
// Reset (synchronous, active low): all entries invalid, ranks and occupancy zero,
// capacity_in_use 16; the key and data RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lkv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_addr  (paddr),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata)
    );

endmodule

`default_nettype wire

@@ test/tb_lru_key_value_cache.sv @@
// Self-checking testbench for lru_key_value_cache: random and directed lookup/store
// beats against a recency-rank shadow of the cache, capacity set over the APB port.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache
    import lkv_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 25;
    localparam int BLOCK_ITEMS  = 117;
    localparam int POOL_SIZE    = 48;

    class lru_shadow;
        logic [KEY_W-1:0]  shadow_key[ENTRIES];
        logic [DATA_W-1:0] shadow_data[ENTRIES];
        bit                shadow_valid[ENTRIES];
        int unsigned       shadow_rank[ENTRIES];
        int unsigned       fill;
        logic [CAP_W-1:0]  capacity;
        t_out_item         expected_results[$];
        int unsigned       error_count;

        function new();
            capacity    = CAP_RESET;
            fill        = 0;
            error_count = 0;
            foreach (shadow_valid[i]) begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i]  = 0;
            end
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void make_recent(int idx);
            int unsigned r;
            r = shadow_rank[idx];
            foreach (shadow_valid[i])
                if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
            shadow_rank[idx] = 0;
        endfunction

        function void note_input(t_in_item item);
            t_out_item   res;
            int          found;
            int          oldest;
            int          slot;
            int unsigned limit;
            res.hit         = 1'b0;
            res.read_value  = MISS_VALUE;
            res.evicted     = 1'b0;
            res.evicted_key = '0;
            found           = -1;
            foreach (shadow_valid[i])
                if (found < 0 && shadow_valid[i] && shadow_key[i] == item.key) found = i;
            if (found >= 0) begin
                res.hit = 1'b1;
                if (item.kind == KIND_LOOKUP) res.read_value = shadow_data[found];
                else shadow_data[found] = item.store_value;
                make_recent(found);
            end else if (item.kind == KIND_STORE) begin
                limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
                if (fill >= limit && fill > 0) begin
                    oldest = -1;
                    foreach (shadow_valid[i])
                        if (shadow_valid[i] &&
                            (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                            oldest = i;
                    if (oldest >= 0) begin
                        res.evicted          = 1'b1;
                        res.evicted_key      = shadow_key[oldest];
                        shadow_valid[oldest] = 1'b0;
                        shadow_rank[oldest]  = 0;
                        fill--;
                    end
                end
                slot = -1;
                foreach (shadow_valid[i])
                    if (slot < 0 && !shadow_valid[i]) slot = i;
                if (slot >= 0) begin
                    foreach (shadow_valid[i])
                        if (shadow_valid[i]) shadow_rank[i]++;
                    shadow_valid[slot] = 1'b1;
                    shadow_key[slot]   = item.key;
                    shadow_data[slot]  = item.store_value;
                    shadow_rank[slot]  = 0;
                    fill++;
                end
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: hit=%0b rd=%h ev=%0b evk=%h",
                             got.hit, got.read_value, got.evicted, got.evicted_key);
                return;
            end
            exp = expected_results.pop_front();
            if (got.hit !== exp.hit || got.read_value !== exp.read_value ||
                got.evicted !== exp.evicted || got.evicted_key !== exp.evicted_key) begin
                error_count++;
                if (error_count <= 10)
                    $display({"mismatch: exp hit=%0b rd=%h ev=%0b evk=%h, ",
                              "got hit=%0b rd=%h ev=%0b evk=%h"},
                             exp.hit, exp.read_value, exp.evicted, exp.evicted_key,
                             got.hit, got.read_value, got.evicted, got.evicted_key);
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_data   = '0;
    logic              i_out_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_data;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lru_shadow         shadow;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       cycle_count   = 0;
    logic [KEY_W-1:0]  key_pool[POOL_SIZE];

    lru_key_value_cache dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) shadow.check_result(o_out_data);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic t_in_item make_item(logic kind, logic [31:0] key, logic [31:0] value);
        t_in_item item;
        item.kind        = kind;
        item.key         = key;
        item.store_value = value;
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.note_input(item);
    endtask

    task automatic wait_drained();
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_CAPACITY);
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_capacity(value);
    endtask

    task automatic run_random_block(input logic [CAP_W-1:0] cap);
        int unsigned span;
        int unsigned eff;
        logic [31:0] key;
        logic [31:0] value;
        eff  = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
        span = 2 * eff + 3;
        if (span > POOL_SIZE) span = POOL_SIZE;
        write_capacity(cap);
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
            key   = ($urandom_range(99) < 88) ? key_pool[$urandom_range(span - 1)] : $urandom;
            value = ($urandom_range(19) == 0)
                  ? {1'($urandom_range(1)), {31{1'($urandom_range(1))}}}
                  : $urandom;
            send_item(make_item($urandom_range(1) ? KIND_STORE : KIND_LOOKUP, key, value));
        end
    endtask

    initial begin
        logic [CAP_W-1:0] block_cap[6];
        shadow      = new();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        block_cap = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd8, 5'd12};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two-entry cache: miss, fill, hit, update, eviction order
        write_capacity(5'd2);
        send_item(make_item(KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678));
        send_item(make_item(KIND_STORE,  32'h8000_0000, 32'h7fff_ffff));
        send_item(make_item(KIND_STORE,  32'h7fff_ffff, 32'h8000_0000));
        send_item(make_item(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000));
        send_item(make_item(KIND_STORE,  32'h0000_0000, 32'hffff_ffff));
        send_item(make_item(KIND_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff));
        send_item(make_item(KIND_STORE,  32'h8000_0000, 32'h0000_0000));
        send_item(make_item(KIND_STORE,  32'hffff_ffff, 32'h5555_aaaa));
        send_item(make_item(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(KIND_LOOKUP, 32'hffff_ffff, 32'h0000_0000));
        send_item(make_item(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000));
        // zero capacity acts as one, below current occupancy
        write_capacity(5'd0);
        send_item(make_item(KIND_STORE,  32'h0000_0005, 32'haaaa_5555));
        send_item(make_item(KIND_STORE,  32'h0000_0006, 32'h0000_0001));
        send_item(make_item(KIND_STORE,  32'h0000_0006, 32'h0000_0002));
        send_item(make_item(KIND_LOOKUP, 32'h0000_0006, 32'h0000_0000));
        send_item(make_item(KIND_LOOKUP, 32'h0000_0005, 32'h0000_0000));

        for (int b = 0; b < 6; b++) begin
            if (b < 2) begin
                send_idle_pct = 30;
                recv_idle_pct = 72;
            end else if (b < 4) begin
                send_idle_pct = 72;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_block(block_cap[b]);
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.error_count == 0 && shadow.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/lkv_pkg.sv
hdl/lkv_ram.sv
hdl/lkv_ctrl.sv
hdl/lkv_dp.sv
hdl/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
